// ===== hw/rtl/digital_input_alarm_qualifier_defines.svh =====
// Assertion macros used by the checker file of the alarm qualifier.
`ifndef DIGITAL_INPUT_ALARM_QUALIFIER_DEFINES_SVH
`define DIGITAL_INPUT_ALARM_QUALIFIER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define DIAQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define DIAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/diaq_pkg.sv =====
// Types and constants of the digital input alarm qualifier.
package diaq_pkg;

  localparam int ModW       = 3;
  localparam int BitsW      = 16;
  localparam int CntW       = 7;
  localparam int ModeW      = 8;
  localparam int CtW        = 6;
  localparam int LiuW       = 5;
  localparam int LaneW      = CntW + 1;
  localparam int GroupLanes = 8;
  localparam int PaddrW     = 5;
  localparam int PdataW     = 32;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_ENABLE,
    REG_LOOPS,
    REG_LEVEL,
    REG_CONFIRM,
    REG_SWITCH,
    REG_RESUME,
    REG_RELAY,
    REG_TARGET
  } reg_idx_t;

  typedef struct packed {
    logic              alarm_enable;
    logic [LiuW-1:0]   loops_in_use;
    logic [BitsW-1:0]  alarm_level_mask;
    logic [CtW-1:0]    qualify_ticks;
    logic [BitsW-1:0]  switch_mode_mask;
    logic [BitsW-1:0]  resume_mode_mask;
    logic [BitsW-1:0]  relay_action_mask;
    logic [ModeW-1:0]  target_run_mode;
  } cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_t;

endpackage

// ===== hw/rtl/diaq_ifs.sv =====
// Valid/ready channel interfaces for detect ticks and alarm results.
interface diaq_in_if import diaq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ModW-1:0]  module_index;
  logic [BitsW-1:0] loop_bits;

  modport source (output valid, module_index, loop_bits, input ready);
  modport sink   (input valid, module_index, loop_bits, output ready);
endinterface

interface diaq_out_if import diaq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ModW-1:0]  module_id;
  logic [BitsW-1:0] abnormal_mask;
  logic             report_due;
  logic             any_abnormal;
  logic [ModeW-1:0] run_mode;
  logic             relays_forced_off;

  modport source (output valid, module_id, abnormal_mask, report_due, any_abnormal,
                  run_mode, relays_forced_off, input ready);
  modport sink   (input valid, module_id, abnormal_mask, report_due, any_abnormal,
                  run_mode, relays_forced_off, output ready);
endinterface

// ===== hw/rtl/diaq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module diaq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/diaq_cfg.sv =====
// APB-style configuration register file of the alarm qualifier.
module diaq_cfg import diaq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[PaddrW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alarm_enable      <= 1'b0;
      cfg_r.loops_in_use      <= LiuW'(16);
      cfg_r.alarm_level_mask  <= '0;
      cfg_r.qualify_ticks     <= CtW'(3);
      cfg_r.switch_mode_mask  <= '0;
      cfg_r.resume_mode_mask  <= '0;
      cfg_r.relay_action_mask <= '0;
      cfg_r.target_run_mode   <= ModeW'(1);
    end else if (wr) begin
      unique case (idx)
        REG_ENABLE:  cfg_r.alarm_enable      <= pwdata[0];
        REG_LOOPS:   cfg_r.loops_in_use      <= pwdata[LiuW-1:0];
        REG_LEVEL:   cfg_r.alarm_level_mask  <= pwdata[BitsW-1:0];
        REG_CONFIRM: cfg_r.qualify_ticks     <= pwdata[CtW-1:0];
        REG_SWITCH:  cfg_r.switch_mode_mask  <= pwdata[BitsW-1:0];
        REG_RESUME:  cfg_r.resume_mode_mask  <= pwdata[BitsW-1:0];
        REG_RELAY:   cfg_r.relay_action_mask <= pwdata[BitsW-1:0];
        REG_TARGET:  cfg_r.target_run_mode   <= pwdata[ModeW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ENABLE:  prdata = PdataW'(cfg_r.alarm_enable);
      REG_LOOPS:   prdata = PdataW'(cfg_r.loops_in_use);
      REG_LEVEL:   prdata = PdataW'(cfg_r.alarm_level_mask);
      REG_CONFIRM: prdata = PdataW'(cfg_r.qualify_ticks);
      REG_SWITCH:  prdata = PdataW'(cfg_r.switch_mode_mask);
      REG_RESUME:  prdata = PdataW'(cfg_r.resume_mode_mask);
      REG_RELAY:   prdata = PdataW'(cfg_r.relay_action_mask);
      REG_TARGET:  prdata = PdataW'(cfg_r.target_run_mode);
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/diaq_lanes.sv =====
// Per-loop confirm counter update for one module row, all loops side by side.
module diaq_lanes import diaq_pkg::*; #(
  parameter int LOOPS = 16
) (
  input  cfg_t                    cfg,
  input  logic                    act,
  input  logic [BitsW-1:0]        loop_bits,
  input  logic [LOOPS*LaneW-1:0]  row_in,
  output logic [LOOPS*LaneW-1:0]  row_out,
  output logic [LOOPS-1:0]        raise,
  output logic [LOOPS-1:0]        clear
);

  // Update every loop in use from its stored count and alarm flag
  always_comb begin
    logic signed [CntW:0] conf;
    logic signed [CntW:0] neg_conf;
    logic signed [CntW:0] c;
    logic signed [CntW:0] up;
    logic signed [CntW:0] dn;
    logic [CntW-1:0]      cnt;
    logic                 alarmed;
    logic                 match;
    logic                 in_use;

    conf     = (cfg.qualify_ticks == '0) ? (CntW+1)'(1) : (CntW+1)'(cfg.qualify_ticks);
    neg_conf = -conf;
    row_out  = row_in;
    raise    = '0;
    clear    = '0;
    for (int j = 0; j < LOOPS; j++) begin
      cnt     = row_in[j*LaneW +: CntW];
      alarmed = row_in[j*LaneW + CntW];
      match   = (loop_bits[j] == cfg.alarm_level_mask[j]);
      in_use  = act && (LiuW'(j) < cfg.loops_in_use);
      c       = {cnt[CntW-1], cnt};
      up      = c + (CntW+1)'(1);
      dn      = c - (CntW+1)'(1);
      if (in_use) begin
        if (!alarmed) begin
          if (!match) begin
            cnt = '0;
          end else if (up >= conf) begin
            cnt      = conf[CntW-1:0];
            alarmed  = 1'b1;
            raise[j] = 1'b1;
          end else begin
            cnt = up[CntW-1:0];
          end
        end else begin
          if (match) begin
            cnt = '0;
          end else if (dn <= neg_conf) begin
            cnt      = neg_conf[CntW-1:0];
            alarmed  = 1'b0;
            clear[j] = 1'b1;
          end else begin
            cnt = dn[CntW-1:0];
          end
        end
      end
      row_out[j*LaneW +: LaneW] = {alarmed, cnt};
    end
  end

endmodule

// ===== hw/rtl/digital_input_alarm_qualifier.sv =====
// Top level of the digital input alarm qualifier.
//
// One detect tick for one collector module is taken per request on in_if;
// each produces exactly one result on out_if. Counters and alarm flags of a
// module sit in one RAM row, the run modes kept at raise in a second RAM row.
// An item passes through the RAM read, then through one step per group of
// eight loops, because raises and clears change the global run mode in loop
// order and the mode chain walks eight loops per cycle. The last step writes
// the rows back if the item is active (alarms enabled, module in range) and
// loads the result register; it waits only while an earlier result is still
// not taken. A new request is taken once the previous item is finished, even
// while its result waits. Row valid flags give the reset state, so no
// clearing pass runs after reset. Configure only while the block is idle.
module digital_input_alarm_qualifier import diaq_pkg::*; #(
  parameter int MODULES = 8,
  parameter int LOOPS   = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  diaq_in_if.sink           in_if,
  diaq_out_if.source        out_if,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [PaddrW-1:0] cfg_paddr,
  input  logic [PdataW-1:0] cfg_pwdata,
  output logic [PdataW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int MA_W   = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int ROW_W  = LOOPS * LaneW;
  localparam int SV_W   = LOOPS * ModeW;
  localparam int GROUPS = (LOOPS + GroupLanes - 1) / GroupLanes;
  localparam int GI_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int ExtW   = 7;

  cfg_t             cfg;
  state_t           state_r, state_nxt;
  logic [GI_W-1:0]  grp_r, grp_nxt;
  logic [ModW-1:0]  mod_r;
  logic [BitsW-1:0] bits_r;
  logic             inrange_r;
  logic             rowvld_r;
  logic [MODULES-1:0] vld_r;
  logic [ModeW-1:0] mode_r;
  logic             relay_r;
  logic [ModeW-1:0] sv_r [LOOPS];

  logic             out_valid_r;
  logic [ModW-1:0]  out_mod_r;
  logic [BitsW-1:0] out_mask_r;
  logic             out_due_r;
  logic             out_any_r;
  logic [ModeW-1:0] out_mode_r;
  logic             out_relay_r;

  logic             in_accept;
  logic [ExtW-1:0]  mod_in_ext;
  logic [ExtW-1:0]  mod_r_ext;
  logic             in_range_in;
  logic [MA_W-1:0]  rd_addr;
  logic [MA_W-1:0]  wr_addr;
  logic [ROW_W-1:0] rdata_a, row_a_old, row_a_new;
  logic [SV_W-1:0]  rdata_b, row_b_old, row_b_new;
  logic [LOOPS-1:0] raise, clear, raise_sw, clear_rs, alarm_vec;
  logic             relay_hit;
  logic             act;
  logic             out_free;
  logic             last_grp;
  logic             step;
  logic             fin;
  logic             we;
  logic [ModeW-1:0] mode_after;
  logic [ModeW-1:0] pre_mode [GroupLanes];
  logic             rs_g  [GROUPS][GroupLanes];
  logic             cr_g  [GROUPS][GroupLanes];
  logic [ModeW-1:0] svo_g [GROUPS][GroupLanes];

  // Configuration registers
  diaq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Request decode and RAM addressing
  assign in_accept   = in_if.valid && in_if.ready;
  assign mod_in_ext  = ExtW'(in_if.module_index);
  assign mod_r_ext   = ExtW'(mod_r);
  assign in_range_in = mod_in_ext < ExtW'(MODULES);
  assign rd_addr     = mod_in_ext[MA_W-1:0];
  assign wr_addr     = mod_r_ext[MA_W-1:0];
  assign in_if.ready = (state_r == ST_IDLE);

  diaq_ram #(.WIDTH(ROW_W), .DEPTH(MODULES)) u_ram_cnt (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr),
    .wdata (row_a_new),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (rdata_a)
  );

  diaq_ram #(.WIDTH(SV_W), .DEPTH(MODULES)) u_ram_mode (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr),
    .wdata (row_b_new),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (rdata_b)
  );

  // A row never written reads as its reset value
  assign row_a_old = rowvld_r ? rdata_a : '0;
  assign row_b_old = rowvld_r ? rdata_b : '0;
  assign act       = cfg.alarm_enable && inrange_r;

  diaq_lanes #(.LOOPS(LOOPS)) u_lanes (
    .cfg       (cfg),
    .act       (act),
    .loop_bits (bits_r),
    .row_in    (row_a_old),
    .row_out   (row_a_new),
    .raise     (raise),
    .clear     (clear)
  );

  assign raise_sw  = raise & cfg.switch_mode_mask[LOOPS-1:0];
  assign clear_rs  = clear & cfg.switch_mode_mask[LOOPS-1:0]
                           & cfg.resume_mode_mask[LOOPS-1:0];
  assign relay_hit = |(raise & cfg.relay_action_mask[LOOPS-1:0]);

  // Sequencing
  assign out_free = !out_valid_r || out_if.ready;
  assign last_grp = (grp_r == GI_W'(GROUPS - 1));
  assign step     = (state_r == ST_CALC) && (!last_grp || out_free);
  assign fin      = step && last_grp;
  assign we       = fin && act;

  // Spread lane events into groups of eight
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      for (int k = 0; k < GroupLanes; k++) begin
        if (g * GroupLanes + k < LOOPS) begin
          rs_g[g][k]  = raise_sw[g*GroupLanes + k];
          cr_g[g][k]  = clear_rs[g*GroupLanes + k];
          svo_g[g][k] = row_b_old[(g*GroupLanes + k)*ModeW +: ModeW];
        end else begin
          rs_g[g][k]  = 1'b0;
          cr_g[g][k]  = 1'b0;
          svo_g[g][k] = '0;
        end
      end
    end
  end

  // Walk the run mode through the current group in loop order
  always_comb begin
    logic [ModeW-1:0] mode_v;
    mode_v = mode_r;
    for (int k = 0; k < GroupLanes; k++) begin
      pre_mode[k] = mode_v;
      if (rs_g[grp_r][k]) begin
        mode_v = cfg.target_run_mode;
      end else if (cr_g[grp_r][k]) begin
        mode_v = svo_g[grp_r][k];
      end
    end
    mode_after = mode_v;
  end

  // Merge kept modes: lanes of the group in flight take the chain directly
  always_comb begin
    row_b_new = row_b_old;
    alarm_vec = '0;
    for (int j = 0; j < LOOPS; j++) begin
      alarm_vec[j] = row_a_new[j*LaneW + CntW];
      if (raise_sw[j]) begin
        if (GI_W'(j / GroupLanes) == grp_r) begin
          row_b_new[j*ModeW +: ModeW] = pre_mode[j % GroupLanes];
        end else begin
          row_b_new[j*ModeW +: ModeW] = sv_r[j];
        end
      end
    end
  end

  // Hold kept modes of raising loops of finished groups
  always_ff @(posedge clk) begin
    if (step) begin
      for (int j = 0; j < LOOPS; j++) begin
        if ((GI_W'(j / GroupLanes) == grp_r) && raise_sw[j]) begin
          sv_r[j] <= pre_mode[j % GroupLanes];
        end
      end
    end
  end

  // State machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      grp_r   <= '0;
    end else begin
      state_r <= state_nxt;
      grp_r   <= grp_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    grp_nxt   = grp_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_CALC;
          grp_nxt   = '0;
        end
      end
      ST_CALC: begin
        if (step) begin
          if (last_grp) begin
            state_nxt = ST_IDLE;
          end else begin
            grp_nxt = grp_r + GI_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mod_r     <= in_if.module_index;
      bits_r    <= in_if.loop_bits;
      inrange_r <= in_range_in;
      rowvld_r  <= vld_r[rd_addr];
    end
  end

  // Global state and row valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      mode_r  <= '0;
      relay_r <= 1'b0;
    end else begin
      if (step) begin
        mode_r <= mode_after;
      end
      if (fin) begin
        relay_r <= relay_r | relay_hit;
      end
      if (we) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_mod_r   <= mod_r;
      out_mask_r  <= inrange_r ? BitsW'(alarm_vec) : '0;
      out_due_r   <= |(raise | clear);
      out_any_r   <= inrange_r && (alarm_vec != '0);
      out_mode_r  <= mode_after;
      out_relay_r <= relay_r | relay_hit;
    end
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.module_id         = out_mod_r;
  assign out_if.abnormal_mask     = out_mask_r;
  assign out_if.report_due        = out_due_r;
  assign out_if.any_abnormal      = out_any_r;
  assign out_if.run_mode          = out_mode_r;
  assign out_if.relays_forced_off = out_relay_r;

endmodule

// ===== hw/rtl/diaq_checker.sv =====
// Port-level checker of the alarm qualifier and its bind to the top level.
`include "digital_input_alarm_qualifier_defines.svh"

module diaq_checker import diaq_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [BitsW-1:0] out_abnormal_mask,
  input logic             out_any_abnormal,
  input logic             out_relays_forced_off
);

  // One item in flight: no new request right after one is taken
  `DIAQ_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "request taken while busy")

  // Summary flag agrees with the mask
  `DIAQ_ASSERT_NOW(a_any_matches_mask, out_valid, out_any_abnormal == (out_abnormal_mask != '0), "any_abnormal disagrees with mask")

  // Relay force flag never drops once reported
  `DIAQ_ASSERT_NEXT(a_relay_sticky, out_valid && out_relays_forced_off, !out_valid || out_relays_forced_off, "relay force flag dropped")

  // Stalled result stays offered
  `DIAQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result withdrawn while stalled")

endmodule

bind digital_input_alarm_qualifier diaq_checker u_diaq_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_if.valid),
  .in_ready              (in_if.ready),
  .out_valid             (out_if.valid),
  .out_ready             (out_if.ready),
  .out_abnormal_mask     (out_if.abnormal_mask),
  .out_any_abnormal      (out_if.any_abnormal),
  .out_relays_forced_off (out_if.relays_forced_off)
);
